>>> rtl/core/agq_pkg.sv
package agq_pkg;

    localparam logic [7:0] MAX_SUBSTEPS  = 8'd255;
    localparam logic [2:0] STABLE_FRAMES = 3'd4;

    // divider lanes: four averages, then scale lowered and scale raised
    localparam int unsigned DIV_LANES = 6;
    localparam int unsigned DIV_W     = 56;
    localparam int unsigned DIV_STEPS = DIV_W / 8;
    localparam logic [2:0]  DIV_LAST  = 3'(DIV_STEPS - 1);

    localparam logic [1:0] ADJ_HELD    = 2'd0;
    localparam logic [1:0] ADJ_LOWERED = 2'd1;
    localparam logic [1:0] ADJ_RAISED  = 2'd2;

    localparam logic [1:0] POL_FIXED     = 2'd0;
    localparam logic [1:0] POL_SCREEN    = 2'd1;
    localparam logic [1:0] POL_NUMERICAL = 2'd2;
    localparam logic [1:0] POL_EQUATION  = 2'd3;

    localparam logic [2:0] REG_POLICY        = 3'd0;
    localparam logic [2:0] REG_TARGET_FRAME  = 3'd1;
    localparam logic [2:0] REG_TARGET_VISUAL = 3'd2;
    localparam logic [2:0] REG_TARGET_NUM    = 3'd3;
    localparam logic [2:0] REG_TARGET_MEMORY = 3'd4;
    localparam logic [2:0] REG_MIN_SCALE     = 3'd5;
    localparam logic [2:0] REG_MAX_SCALE     = 3'd6;
    localparam logic [2:0] REG_SAMPLE_LIMITS = 3'd7;

    localparam logic [31:0] RST_TARGET_FRAME  = 32'd1092267;
    localparam logic [31:0] RST_TARGET_VISUAL = 32'd65536;
    localparam logic [15:0] RST_MIN_SCALE     = 16'd8192;
    localparam logic [15:0] RST_MAX_SCALE     = 16'd16384;
    localparam logic [15:0] RST_SAMPLE_LIMITS = 16'd4097;

    typedef struct packed {
        logic        command;
        logic [31:0] frame_time;
        logic        has_numerical;
        logic [31:0] numerical_error;
        logic        has_visual;
        logic [31:0] visual_error;
        logic        has_memory;
        logic [47:0] memory_bytes;
        logic [15:0] initial_scale;
        logic [7:0]  initial_samples;
        logic [7:0]  initial_substeps;
    } t_in_item;

    typedef struct packed {
        logic [15:0] resolution_scale;
        logic [7:0]  samples_per_pixel;
        logic [7:0]  simulation_substeps;
        logic [1:0]  adjustment;
        logic        changed;
        logic [31:0] change_count;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  policy;
        logic [31:0] target_frame_time;
        logic [31:0] target_visual_error;
        logic [31:0] target_numerical_error;
        logic [47:0] target_memory;
        logic [15:0] min_scale;
        logic [15:0] max_scale;
        logic [15:0] sample_limits;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPDATE,
        ST_EVAL,
        ST_CMP,
        ST_APPLY
    } t_back_state;

    // eight restoring steps of a division by a small constant divisor
    function automatic logic [12:0] div8(input logic [4:0] rem, input logic [7:0] din,
                                         input logic [4:0] dv);
        logic [5:0] t;
        logic [4:0] r;
        logic [7:0] q;
        r = rem;
        q = '0;
        for (int i = 7; i >= 0; i--) begin
            t = {r, din[i]};
            if (t >= {1'b0, dv}) begin
                t    = t - {1'b0, dv};
                q[i] = 1'b1;
            end
            r = t[4:0];
        end
        return {r, q};
    endfunction

endpackage

>>> rtl/core/agq_front.sv
module agq_front
    import agq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    output logic     o_q_valid,
    input  logic     i_q_ready,
    output t_in_item o_q_data
);

    t_in_item   r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_in_ready = (r_count != 2'd2);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_data   = r_mem[r_rd];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (pop)  r_rd <= !r_rd;
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> rtl/core/agq_back.sv
module agq_back
    import agq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_policy_chg,
    input  logic      i_q_valid,
    output logic      o_q_ready,
    input  t_in_item  i_q_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    function automatic logic [DIV_W-1:0] blend_num(input logic [47:0] avg,
                                                   input logic [47:0] x);
        logic [53:0] n;
        n = 54'(x) * 54'd3 + 54'(avg) * 54'd17 + 54'd10;
        return {4'b0, n[53:2]};
    endfunction

    t_back_state r_state, n_state;

    t_in_item         r_item;
    logic [DIV_W-1:0] r_lane [DIV_LANES];
    logic [4:0]       r_rem  [DIV_LANES];
    logic [2:0]       r_cnt;

    logic [31:0] r_fa, r_na, r_va;
    logic [47:0] r_ma;
    logic        r_fv, r_nv, r_vv, r_mv;
    logic [15:0] r_scale;
    logic [7:0]  r_samples, r_substeps;
    logic [2:0]  r_stable;
    logic [31:0] r_changes;

    logic [37:0] r_f25, r_f27t, r_f50, r_f39t;
    logic [37:0] r_v25, r_v26t, r_v10, r_v7t;
    logic [37:0] r_n25, r_n26t, r_n10, r_n7t;
    logic [52:0] r_m20, r_m17t;
    logic        r_press, r_errp, r_comf;

    logic        r_out_valid;
    t_out_item   r_out;

    logic        vis_req, num_req;
    logic [31:0] num_tgt;
    logic [7:0]  min_s, max_s;
    logic        accept, out_free, apply;

    logic [15:0] n_scale;
    logic [7:0]  n_samples, n_substeps;
    logic [2:0]  n_stable;
    logic [1:0]  n_adj;
    logic        n_changed;
    logic [15:0] q23;
    logic [16:0] q26;
    logic [2:0]  st1;
    logic        do_raise, do_lower;

    assign vis_req = (i_cfg.policy == POL_SCREEN) || (i_cfg.policy == POL_EQUATION);
    assign num_req = (i_cfg.policy == POL_NUMERICAL) ||
                     ((i_cfg.policy == POL_EQUATION) && (i_cfg.target_numerical_error != '0));
    assign num_tgt = (i_cfg.target_numerical_error != '0) ? i_cfg.target_numerical_error
                                                         : i_cfg.target_visual_error;
    assign min_s   = i_cfg.sample_limits[7:0];
    assign max_s   = i_cfg.sample_limits[15:8];

    assign o_q_ready   = (r_state == ST_IDLE);
    assign accept      = i_q_valid && o_q_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign apply       = (r_state == ST_APPLY) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (accept) n_state = i_q_data.command ? ST_APPLY : ST_DIV;
            ST_DIV:    if (r_cnt == DIV_LAST) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_EVAL;
            ST_EVAL:   n_state = ST_CMP;
            ST_CMP:    n_state = ST_APPLY;
            ST_APPLY:  if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // lane dividers: eight quotient bits per lane per cycle
    always_ff @(posedge i_clk) begin
        logic [12:0] res;
        if (r_state == ST_IDLE && accept) begin
            r_item    <= i_q_data;
            r_cnt     <= '0;
            r_lane[0] <= blend_num({16'b0, r_fa}, {16'b0, i_q_data.frame_time});
            r_lane[1] <= blend_num({16'b0, r_na}, {16'b0, i_q_data.numerical_error});
            r_lane[2] <= blend_num({16'b0, r_va}, {16'b0, i_q_data.visual_error});
            r_lane[3] <= blend_num(r_ma, i_q_data.memory_bytes);
            r_lane[4] <= DIV_W'(r_scale) * DIV_W'(23);
            r_lane[5] <= DIV_W'(r_scale) * DIV_W'(26);
            for (int l = 0; l < DIV_LANES; l++) r_rem[l] <= '0;
        end else if (r_state == ST_DIV) begin
            r_cnt <= r_cnt + 3'd1;
            for (int l = 0; l < DIV_LANES; l++) begin
                res       = div8(r_rem[l], r_lane[l][DIV_W-1 -: 8], (l < 4) ? 5'd5 : 5'd25);
                r_lane[l] <= {r_lane[l][DIV_W-9:0], res[7:0]};
                r_rem[l]  <= res[12:8];
            end
        end
    end

    // comparison operands and then flags
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EVAL) begin
            r_f25  <= 38'(r_fa) * 38'd25;
            r_f27t <= 38'(i_cfg.target_frame_time) * 38'd27;
            r_f50  <= 38'(r_fa) * 38'd50;
            r_f39t <= 38'(i_cfg.target_frame_time) * 38'd39;
            r_v25  <= 38'(r_va) * 38'd25;
            r_v26t <= 38'(i_cfg.target_visual_error) * 38'd26;
            r_v10  <= 38'(r_va) * 38'd10;
            r_v7t  <= 38'(i_cfg.target_visual_error) * 38'd7;
            r_n25  <= 38'(r_na) * 38'd25;
            r_n26t <= 38'(num_tgt) * 38'd26;
            r_n10  <= 38'(r_na) * 38'd10;
            r_n7t  <= 38'(num_tgt) * 38'd7;
            r_m20  <= 53'(r_ma) * 53'd20;
            r_m17t <= 53'(i_cfg.target_memory) * 53'd17;
        end
        if (r_state == ST_CMP) begin
            r_errp  <= (vis_req && r_vv && (r_v25 > r_v26t)) ||
                       (num_req && r_nv && (r_n25 > r_n26t));
            r_press <= (r_f25 > r_f27t) ||
                       (vis_req && r_vv && (r_v25 > r_v26t)) ||
                       (num_req && r_nv && (r_n25 > r_n26t)) ||
                       ((i_cfg.target_memory != '0) && r_mv && (r_ma > i_cfg.target_memory));
            r_comf  <= (r_f50 < r_f39t) &&
                       (!vis_req || (r_vv && (r_v10 < r_v7t))) &&
                       (!num_req || (r_nv && (r_n10 < r_n7t))) &&
                       ((i_cfg.target_memory == '0) || !r_mv || (r_m20 < r_m17t));
        end
    end

    // decision and new quality state
    always_comb begin
        q23        = r_lane[4][15:0];
        q26        = r_lane[5][16:0];
        st1        = r_stable + 3'd1;
        do_raise   = 1'b0;
        do_lower   = 1'b0;
        n_scale    = r_scale;
        n_samples  = r_samples;
        n_substeps = r_substeps;
        n_stable   = '0;
        n_adj      = ADJ_HELD;
        n_changed  = 1'b0;
        if (r_item.command) begin
            n_scale = r_item.initial_scale;
            if (r_item.initial_scale < i_cfg.min_scale)      n_scale = i_cfg.min_scale;
            else if (r_item.initial_scale > i_cfg.max_scale) n_scale = i_cfg.max_scale;
            n_samples = r_item.initial_samples;
            if (r_item.initial_samples < min_s)      n_samples = min_s;
            else if (r_item.initial_samples > max_s) n_samples = max_s;
            n_substeps = r_item.initial_substeps;
            if (n_substeps == 8'd0)         n_substeps = 8'd1;
            if (n_substeps > MAX_SUBSTEPS)  n_substeps = MAX_SUBSTEPS;
        end else if (!((r_item.command == 1'b0) && ((i_cfg.policy == POL_FIXED) ||
                     (vis_req && !r_vv) || (num_req && !r_nv)))) begin
            if (r_press) begin
                do_raise = r_errp;
                do_lower = !r_errp;
            end else if (r_comf) begin
                if (st1 >= STABLE_FRAMES) do_raise = 1'b1;
                else                      n_stable = st1;
            end
            if (do_lower) begin
                n_adj   = ADJ_LOWERED;
                n_scale = (q23 < i_cfg.min_scale) ? i_cfg.min_scale : q23;
                if (r_samples > min_s)      n_samples  = r_samples - 8'd1;
                if (r_substeps > 8'd1)      n_substeps = r_substeps - 8'd1;
            end
            if (do_raise) begin
                n_adj   = ADJ_RAISED;
                n_scale = (q26 > {1'b0, i_cfg.max_scale}) ? i_cfg.max_scale : q26[15:0];
                if (r_samples < max_s) n_samples = r_samples + 8'd1;
                if (num_req && r_nv && (r_substeps < MAX_SUBSTEPS))
                    n_substeps = r_substeps + 8'd1;
            end
            n_changed = (n_scale != r_scale) || (n_samples != r_samples) ||
                        (n_substeps != r_substeps);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv        <= 1'b0;
            r_nv        <= 1'b0;
            r_vv        <= 1'b0;
            r_mv        <= 1'b0;
            r_fa        <= '0;
            r_na        <= '0;
            r_va        <= '0;
            r_ma        <= '0;
            r_scale     <= RST_MAX_SCALE;
            r_samples   <= RST_SAMPLE_LIMITS[7:0];
            r_substeps  <= 8'd1;
            r_stable    <= '0;
            r_changes   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !apply) r_out_valid <= 1'b0;
            if (i_policy_chg && !apply) r_stable <= '0;
            if (r_state == ST_UPDATE) begin
                r_fa <= r_fv ? r_lane[0][31:0] : r_item.frame_time;
                r_fv <= 1'b1;
                if (r_item.has_numerical) begin
                    r_na <= r_nv ? r_lane[1][31:0] : r_item.numerical_error;
                    r_nv <= 1'b1;
                end
                if (r_item.has_visual) begin
                    r_va <= r_vv ? r_lane[2][31:0] : r_item.visual_error;
                    r_vv <= 1'b1;
                end
                if (r_item.has_memory) begin
                    r_ma <= r_mv ? r_lane[3][47:0] : r_item.memory_bytes;
                    r_mv <= 1'b1;
                end
            end
            if (apply) begin
                r_scale    <= n_scale;
                r_samples  <= n_samples;
                r_substeps <= n_substeps;
                r_stable   <= n_stable;
                if (r_item.command) begin
                    r_fv      <= 1'b0;
                    r_nv      <= 1'b0;
                    r_vv      <= 1'b0;
                    r_mv      <= 1'b0;
                    r_fa      <= '0;
                    r_na      <= '0;
                    r_va      <= '0;
                    r_ma      <= '0;
                    r_changes <= '0;
                end else if (n_changed) begin
                    r_changes <= r_changes + 32'd1;
                end
                r_out_valid            <= 1'b1;
                r_out.resolution_scale    <= n_scale;
                r_out.samples_per_pixel   <= n_samples;
                r_out.simulation_substeps <= n_substeps;
                r_out.adjustment          <= n_adj;
                r_out.changed             <= n_changed;
                r_out.change_count        <= r_item.command ? 32'd0 :
                                             (r_changes + {31'b0, n_changed});
            end
        end
    end

endmodule

>>> rtl/core/adaptive_quality_governor.sv
// Adaptive quality governor: takes one request per rendered frame, either a
// measurement (frame time plus optional numerical error, visual error and GPU
// memory) or a restart carrying an initial quality state, and returns exactly
// one result per request with the current resolution scale, samples per pixel,
// simulation substeps, the adjustment made and the wrapping change count.
// A measurement passes through the shared-rate lane dividers (eight quotient
// bits per cycle over a 56-bit numerator, all averages and both scale
// candidates in parallel), then the back updates the averages, forms the
// comparison operands and compares, and its apply step loads the result
// register. A restart goes straight from being taken to the apply step. The
// back takes a new request only when idle, after applying the last one, and
// holds in its apply step while the previous result waits. A two-deep request
// queue lets the next request be taken while one is in work, and the result
// register holds its result until taken. Write configuration only while the
// block is idle.
module adaptive_quality_governor
    import agq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);

    t_cfg     r_cfg;
    logic     policy_chg;
    logic     q_valid;
    logic     q_ready;
    t_in_item q_data;

    // a policy write that changes the policy restarts the comfort run
    assign policy_chg = i_cfg_we && (i_cfg_idx == REG_POLICY) &&
                        (i_cfg_data[1:0] != r_cfg.policy);

    // configuration registers; hold their values between writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy                 <= POL_FIXED;
            r_cfg.target_frame_time      <= RST_TARGET_FRAME;
            r_cfg.target_visual_error    <= RST_TARGET_VISUAL;
            r_cfg.target_numerical_error <= '0;
            r_cfg.target_memory          <= '0;
            r_cfg.min_scale              <= RST_MIN_SCALE;
            r_cfg.max_scale              <= RST_MAX_SCALE;
            r_cfg.sample_limits          <= RST_SAMPLE_LIMITS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_POLICY:        r_cfg.policy                 <= i_cfg_data[1:0];
                REG_TARGET_FRAME:  r_cfg.target_frame_time      <= i_cfg_data[31:0];
                REG_TARGET_VISUAL: r_cfg.target_visual_error    <= i_cfg_data[31:0];
                REG_TARGET_NUM:    r_cfg.target_numerical_error <= i_cfg_data[31:0];
                REG_TARGET_MEMORY: r_cfg.target_memory          <= i_cfg_data;
                REG_MIN_SCALE:     r_cfg.min_scale              <= i_cfg_data[15:0];
                REG_MAX_SCALE:     r_cfg.max_scale              <= i_cfg_data[15:0];
                REG_SAMPLE_LIMITS: r_cfg.sample_limits          <= i_cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    // front: queue requests so the back can stall on its own
    agq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .i_q_ready  (q_ready),
        .o_q_data   (q_data)
    );

    // back: average, judge pressure and comfort, adjust quality
    agq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_policy_chg (policy_chg),
        .i_q_valid    (q_valid),
        .o_q_ready    (q_ready),
        .i_q_data     (q_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

`ifndef ASSERT_OFF
    a_changed_needs_adjust: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.changed) |-> (o_out_data.adjustment != ADJ_HELD))
        else $error("quality changed on a held step");

    a_substeps_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.simulation_substeps != 8'd0))
        else $error("substeps reached zero");

    a_restart_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.adjustment == ADJ_HELD) |-> !o_out_data.changed)
        else $error("held result flagged as changed");
`endif

endmodule

>>> dv/tb_checker.sv
module tb_checker
    import agq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg        cfg;
    logic [31:0] avg_frame, avg_num, avg_vis;
    logic [47:0] avg_mem;
    logic        ok_frame, ok_num, ok_vis, ok_mem;
    logic [15:0] scale;
    logic [7:0]  samples, substeps;
    logic [2:0]  run;
    logic [31:0] changes;
    t_out_item   governor_q[$];

    assign o_pending = governor_q.size();

    function automatic logic [47:0] ewma(input logic [47:0] a, input logic [47:0] x);
        logic [63:0] s;
        s = (64'(x) * 3 + 64'(a) * 17 + 10) / 20;
        return s[47:0];
    endfunction

    function automatic logic vis_req();
        return cfg.policy == POL_SCREEN || cfg.policy == POL_EQUATION;
    endfunction

    function automatic logic num_req();
        return cfg.policy == POL_NUMERICAL ||
               (cfg.policy == POL_EQUATION && cfg.target_numerical_error != 0);
    endfunction

    function automatic logic [63:0] num_tgt();
        return cfg.target_numerical_error != 0 ? 64'(cfg.target_numerical_error)
                                               : 64'(cfg.target_visual_error);
    endfunction

    function automatic logic vis_press();
        return vis_req() && ok_vis &&
               64'(avg_vis) * 25 > 64'(cfg.target_visual_error) * 26;
    endfunction

    function automatic logic num_press();
        return num_req() && ok_num && 64'(avg_num) * 25 > num_tgt() * 26;
    endfunction

    task automatic lower_q();
        logic [31:0] s;
        s = 32'(scale) * 23 / 25;
        scale = s < 32'(cfg.min_scale) ? cfg.min_scale : s[15:0];
        if (samples > cfg.sample_limits[7:0]) samples--;
        if (substeps > 1) substeps--;
    endtask

    task automatic raise_q();
        logic [31:0] s;
        s = 32'(scale) * 26 / 25;
        scale = s > 32'(cfg.max_scale) ? cfg.max_scale : s[15:0];
        if (samples < cfg.sample_limits[15:8]) samples++;
        if (num_req() && ok_num && substeps < MAX_SUBSTEPS) substeps++;
    endtask

    task automatic predict(input t_in_item it);
        t_out_item   r;
        logic        press, comfy;
        logic [15:0] ps;
        logic [7:0]  pn, pb, lo, hi;
        r = '0;
        lo = cfg.sample_limits[7:0];
        hi = cfg.sample_limits[15:8];
        if (it.command) begin
            // clamp with the minimum taking precedence when limits are inverted
            if (it.initial_scale < cfg.min_scale) scale = cfg.min_scale;
            else if (it.initial_scale > cfg.max_scale) scale = cfg.max_scale;
            else scale = it.initial_scale;
            if (it.initial_samples < lo) samples = lo;
            else if (it.initial_samples > hi) samples = hi;
            else samples = it.initial_samples;
            substeps = it.initial_substeps == 0 ? 8'd1 : it.initial_substeps;
            {ok_frame, ok_num, ok_vis, ok_mem} = '0;
            {avg_frame, avg_num, avg_vis, avg_mem} = '0;
            run = 0;
            changes = 0;
        end else begin
            avg_frame = ok_frame ? 32'(ewma(48'(avg_frame), 48'(it.frame_time)))
                                 : it.frame_time;
            ok_frame = 1;
            if (it.has_numerical) begin
                avg_num = ok_num ? 32'(ewma(48'(avg_num), 48'(it.numerical_error)))
                                 : it.numerical_error;
                ok_num = 1;
            end
            if (it.has_visual) begin
                avg_vis = ok_vis ? 32'(ewma(48'(avg_vis), 48'(it.visual_error)))
                                 : it.visual_error;
                ok_vis = 1;
            end
            if (it.has_memory) begin
                avg_mem = ok_mem ? ewma(avg_mem, it.memory_bytes) : it.memory_bytes;
                ok_mem = 1;
            end
            if (cfg.policy == POL_FIXED || (vis_req() && !ok_vis) || (num_req() && !ok_num)) begin
                run = 0;
            end else begin
                ps = scale;
                pn = samples;
                pb = substeps;
                press = 64'(avg_frame) * 25 > 64'(cfg.target_frame_time) * 27 ||
                        vis_press() || num_press() ||
                        (cfg.target_memory != 0 && ok_mem && avg_mem > cfg.target_memory);
                comfy = 64'(avg_frame) * 50 < 64'(cfg.target_frame_time) * 39 &&
                        (!vis_req() || (ok_vis &&
                            64'(avg_vis) * 10 < 64'(cfg.target_visual_error) * 7)) &&
                        (!num_req() || (ok_num && 64'(avg_num) * 10 < num_tgt() * 7)) &&
                        (cfg.target_memory == 0 || !ok_mem ||
                            64'(avg_mem) * 20 < 64'(cfg.target_memory) * 17);
                if (press) begin
                    // error pressure raises quality, anything else lowers it
                    if (vis_press() || num_press()) begin
                        raise_q();
                        r.adjustment = ADJ_RAISED;
                    end else begin
                        lower_q();
                        r.adjustment = ADJ_LOWERED;
                    end
                    run = 0;
                end else if (comfy) begin
                    run++;
                    if (run >= STABLE_FRAMES) begin
                        raise_q();
                        r.adjustment = ADJ_RAISED;
                        run = 0;
                    end
                end else begin
                    run = 0;
                end
                if (ps != scale || pn != samples || pb != substeps) begin
                    r.changed = 1;
                    changes++;
                end
            end
        end
        r.resolution_scale    = scale;
        r.samples_per_pixel   = samples;
        r.simulation_substeps = substeps;
        r.change_count        = changes;
        governor_q.push_back(r);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            cfg = {POL_FIXED, RST_TARGET_FRAME, RST_TARGET_VISUAL, 32'd0, 48'd0,
                   RST_MIN_SCALE, RST_MAX_SCALE, RST_SAMPLE_LIMITS};
            {avg_frame, avg_num, avg_vis, avg_mem} = '0;
            {ok_frame, ok_num, ok_vis, ok_mem} = '0;
            scale = RST_MAX_SCALE;
            samples = RST_SAMPLE_LIMITS[7:0];
            substeps = 1;
            run = 0;
            changes = 0;
            governor_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_POLICY: begin
                        if (i_cfg_data[1:0] != cfg.policy) run = 0;
                        cfg.policy = i_cfg_data[1:0];
                    end
                    REG_TARGET_FRAME:  cfg.target_frame_time = i_cfg_data[31:0];
                    REG_TARGET_VISUAL: cfg.target_visual_error = i_cfg_data[31:0];
                    REG_TARGET_NUM:    cfg.target_numerical_error = i_cfg_data[31:0];
                    REG_TARGET_MEMORY: cfg.target_memory = i_cfg_data;
                    REG_MIN_SCALE:     cfg.min_scale = i_cfg_data[15:0];
                    REG_MAX_SCALE:     cfg.max_scale = i_cfg_data[15:0];
                    REG_SAMPLE_LIMITS: cfg.sample_limits = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (governor_q.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    e = governor_q.pop_front();
                    if (i_out_data.resolution_scale != e.resolution_scale)
                        report("scale", i_out_data.resolution_scale, e.resolution_scale);
                    if (i_out_data.samples_per_pixel != e.samples_per_pixel)
                        report("samples", i_out_data.samples_per_pixel, e.samples_per_pixel);
                    if (i_out_data.simulation_substeps != e.simulation_substeps)
                        report("substeps", i_out_data.simulation_substeps,
                               e.simulation_substeps);
                    if (i_out_data.adjustment != e.adjustment)
                        report("adjustment", i_out_data.adjustment, e.adjustment);
                    if (i_out_data.changed != e.changed)
                        report("changed", i_out_data.changed, e.changed);
                    if (i_out_data.change_count != e.change_count)
                        report("change count", i_out_data.change_count, e.change_count);
                end
            end
        end
    end

    initial o_errors = 0;

endmodule

>>> dv/tb_top.sv
module tb_top;
    import agq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_ready = 0;
    t_out_item   out_data;
    logic        cfg_we = 0;
    logic [2:0]  cfg_idx = REG_POLICY;
    logic [47:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    // sink behaviour: 0 random stalls, 1 always ready, 2 long hold-off
    int          sink_mode = 0;
    int          fill_cycles = 0;

    adaptive_quality_governor dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tb_checker chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_data  (in_data),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // sink: random stalls, a clean stretch, and one long hold-off on request
    always @(negedge clk) begin
        if (sink_mode == 2) begin
            out_ready <= 0;
            fill_cycles <= fill_cycles + 1;
            if (fill_cycles >= 60) begin
                sink_mode <= 0;
                fill_cycles <= 0;
            end
        end else if (sink_mode == 1) begin
            out_ready <= 1;
        end else begin
            out_ready <= $urandom_range(99) >= 34;
        end
    end

    // watchdog: abort when nothing moves for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("watchdog expired");
            $display("** adaptive_quality_governor: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        cfg_we   <= 1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 0;
    endtask

    // offer one request, hold it until taken; valid drops only on a gap or a drain
    task automatic send(input t_in_item it, input bit gaps);
        while (gaps && $urandom_range(99) < 34) begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic t_in_item rand_item(input bit restart);
        t_in_item it;
        it = $bits(t_in_item)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.command = restart;
        // keep measurements near the targets so pressure and comfort both occur
        if ($urandom_range(3) != 0) begin
            it.frame_time      = $urandom_range(32'd1400000, 32'd500000);
            it.numerical_error = $urandom_range(32'd90000, 32'd30000);
            it.visual_error    = $urandom_range(32'd90000, 32'd30000);
            it.memory_bytes    = 48'($urandom_range(1500, 500));
        end
        it.has_numerical = $urandom_range(9) != 0;
        it.has_visual    = $urandom_range(9) != 0;
        it.has_memory    = $urandom_range(3) != 0;
        return it;
    endfunction

    task automatic measure(input logic [31:0] ft, input logic [31:0] ne,
                           input logic [31:0] ve, input logic [47:0] mb);
        t_in_item it;
        it = '0;
        it.frame_time = ft;
        it.has_numerical = 1;
        it.numerical_error = ne;
        it.has_visual = 1;
        it.visual_error = ve;
        it.has_memory = 1;
        it.memory_bytes = mb;
        send(it, 1);
    endtask

    task automatic restart(input logic [15:0] sc, input logic [7:0] sa, input logic [7:0] sb);
        t_in_item it;
        it = '0;
        it.command = 1;
        it.initial_scale = sc;
        it.initial_samples = sa;
        it.initial_substeps = sb;
        send(it, 1);
    endtask

    task automatic set_targets(input logic [1:0] pol, input logic [31:0] tn,
                               input logic [47:0] tm, input logic [15:0] lo,
                               input logic [15:0] hi, input logic [15:0] sl);
        write_reg(REG_POLICY, 48'(pol));
        write_reg(REG_TARGET_FRAME, 48'd1000000);
        write_reg(REG_TARGET_VISUAL, 48'd65536);
        write_reg(REG_TARGET_NUM, 48'(tn));
        write_reg(REG_TARGET_MEMORY, tm);
        write_reg(REG_MIN_SCALE, 48'(lo));
        write_reg(REG_MAX_SCALE, 48'(hi));
        write_reg(REG_SAMPLE_LIMITS, 48'(sl));
    endtask

    initial begin
        int phase_items;
        repeat (3) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: reset state, then each policy with the extremes
        measure('1, '1, '1, '1);
        measure('0, '0, '0, '0);
        drain();
        write_reg(REG_POLICY, 48'(POL_SCREEN));
        measure(32'd1000, 32'd0, 32'd1000, 48'd0);
        repeat (5) measure(32'd1000, 32'd0, 32'd1000, 48'd0);
        measure(32'hFFFF_FFFF, 32'd0, 32'd1000, 48'd0);
        measure(32'd1000, 32'd0, 32'hFFFF_FFFF, 48'd0);
        restart(16'hFFFF, 8'hFF, 8'h00);
        restart(16'h0000, 8'h00, 8'hFF);
        drain();
        set_targets(POL_EQUATION, 32'd40000, 48'hFFFF_FFFF_FFFF, 16'd1, 16'd65535, 16'hFF00);
        measure(32'd1000, 32'hFFFF_FFFF, 32'd1000, 48'd5);
        repeat (4) measure(32'd1000, 32'd10, 32'd10, 48'd5);
        drain();
        set_targets(POL_NUMERICAL, 32'd0, 48'd1000, 16'd9000, 16'd4000, 16'h0408);
        restart(16'd5000, 8'd6, 8'd3);
        measure(32'd1000, 32'd10, 32'd10, 48'd5000);
        measure(32'd2000000, 32'd10, 32'd10, 48'd5000);
        drain();

        // random phases over several settings, extremes among them
        for (int ph = 0; ph < 8; ph++) begin
            set_targets(2'($urandom_range(3)),
                        ph[0] ? 32'd0 : 32'($urandom_range(80000, 40000)),
                        ph[1] ? 48'd0 : 48'($urandom_range(1500, 600)),
                        ph == 7 ? 16'd1 : 16'($urandom_range(10000, 4000)),
                        ph == 7 ? 16'hFFFF : 16'($urandom_range(20000, 12000)),
                        ph == 6 ? 16'hFFFF : 16'({8'($urandom_range(255, 8)),
                                                  8'($urandom_range(4))}));
            phase_items = 75;
            if (ph == 2) sink_mode = 1;
            if (ph == 3) sink_mode = 0;
            for (int k = 0; k < phase_items; k++) begin
                if (ph == 4 && k == 10) sink_mode = 2;
                send(rand_item($urandom_range(24) == 0), ph != 2);
            end
            // pause until everything has come back
            drain();
        end
        drain();
        if (errors == 0) begin
            $display("** adaptive_quality_governor: PASSED **");
        end else begin
            $display("** adaptive_quality_governor: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/agq_pkg.sv
rtl/core/agq_front.sv
rtl/core/agq_back.sv
rtl/core/adaptive_quality_governor.sv
dv/tb_checker.sv
dv/tb_top.sv
